// ===== src/bpc_pkg.sv =====
// Shared types and constants for the bit pattern correlator.
// No dependencies; every other file of the block but bpc_cell refers to this package.
`timescale 1ns / 1ps

package bpc_pkg;

  // Default sizes for the top-level parameters.
  localparam int DEF_MAX_PATTERN_BITS = 64;
  localparam int DEF_POSITION_BITS    = 16;

  // Fixed field widths.
  localparam int PATTERN_W = 64;
  localparam int PIDX_W    = 6;
  localparam int LEN_W     = 7;
  localparam int CNT_W     = 7;
  localparam int PHASE_W   = 2;
  localparam int OUT_POS_W = 16;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 1;

  // Match bits are counted in groups of this size in the first adder stage.
  localparam int GRP_SIZE = 8;
  localparam int GRP_W    = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 1'd1;

  // Phase codes of a result.
  localparam logic [PHASE_W-1:0] PHASE_LEAD  = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_FULL  = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_TRAIL = 2'd2;

  // Per-result side information that travels alongside the match bits.
  typedef struct packed {
    logic [PHASE_W-1:0]   phase;
    logic                 last;
    logic [LEN_W-1:0]     len;
    logic [OUT_POS_W-1:0] pos;
  } meta_t;

endpackage

// ===== src/bpc_cell.sv =====
// One correlator cell: a stored stream bit with its present flag and a compare
// against the pattern element aligned with it. Does not use bpc_pkg.
`timescale 1ns / 1ps

module bpc_cell (
  input  logic clk,
  input  logic rst,
  input  logic shift,
  input  logic clear,
  input  logic bit_in,
  input  logic present_in,
  input  logic ref_bit,
  input  logic ref_en,
  output logic bit_q,
  output logic present_q,
  output logic match
);

  logic bit_next;
  logic present_next;

  assign bit_next     = shift ? bit_in : bit_q;
  assign present_next = shift ? present_in : present_q;

  // The compare looks at the value the cell takes on this edge, so the count
  // is captured in the same cycle as the shift.
  assign match = ref_en & present_next & (bit_next == ref_bit);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      bit_q     <= 1'b0;
      present_q <= 1'b0;
    end else if (shift) begin
      bit_q     <= bit_next;
      present_q <= present_next;
    end
  end

endmodule

// ===== src/bpc_count.sv =====
// Two-stage registered adder tree that turns the cell match bits into the
// agreement count and holds the result beat. Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_count #(
  parameter int MAX_PATTERN_BITS = bpc_pkg::DEF_MAX_PATTERN_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic [MAX_PATTERN_BITS-1:0]      match_bits,
  input  bpc_pkg::meta_t                   meta,
  output logic                             ready,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [bpc_pkg::CNT_W-1:0]        agree_count,
  output logic                             peak,
  output logic [bpc_pkg::PHASE_W-1:0]      phase,
  output logic [bpc_pkg::OUT_POS_W-1:0]    aligned_position,
  output logic                             last_result
);

  localparam int NGRP = (MAX_PATTERN_BITS + bpc_pkg::GRP_SIZE - 1) / bpc_pkg::GRP_SIZE;

  logic                          s1_valid;
  logic [bpc_pkg::GRP_W-1:0]     s1_grp [NGRP];
  bpc_pkg::meta_t                s1_meta;
  logic [bpc_pkg::GRP_W-1:0]     grp_next [NGRP];
  logic [bpc_pkg::CNT_W-1:0]     sum;
  logic                          s2_ready;

  assign s2_ready = !result_valid || !result_stall;
  assign ready    = !s1_valid || s2_ready;

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_next[g] = '0;
      for (int b = 0; b < bpc_pkg::GRP_SIZE; b++) begin
        if (g * bpc_pkg::GRP_SIZE + b < MAX_PATTERN_BITS) begin
          grp_next[g] = grp_next[g]
                      + bpc_pkg::GRP_W'(match_bits[g * bpc_pkg::GRP_SIZE + b]);
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int g = 0; g < NGRP; g++) begin
      sum = sum + bpc_pkg::CNT_W'(s1_grp[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ready) begin
      s1_valid <= step;
    end
    if (ready && step) begin
      s1_grp  <= grp_next;
      s1_meta <= meta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s2_ready) begin
      result_valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      agree_count      <= sum;
      peak             <= (sum == bpc_pkg::CNT_W'(s1_meta.len));
      phase            <= s1_meta.phase;
      aligned_position <= s1_meta.pos;
      last_result      <= s1_meta.last;
    end
  end

endmodule

// ===== src/bit_pattern_correlator.sv =====
// Top level of the sliding-window bit correlator: configuration registers,
// flush sequencer, the row of bpc_cell instances and the bpc_count adder.
// Depends on bpc_pkg, bpc_cell and bpc_count.
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// --------  -------------------------  ------------------------------------------
// bits      bit_valid / bit_stall      data_bit, end_of_stream
// results   result_valid/result_stall  agree_count, peak, phase, aligned_position,
//                                      last_result
// config    cfg_write                  cfg_index, cfg_data
//
// One stream bit is taken every cycle while bit_stall is low; its result is
// registered in both stages of the adder tree behind the cells.
// A bit marked end_of_stream is followed by a flush with bit_stall high that
// yields len_eff-1 trailing results, one per flush step.
// Reset is synchronous and clears the window, fill count and position.
// A stalled result raises bit_stall only once both adder stages are full.

module bit_pattern_correlator #(
  parameter int MAX_PATTERN_BITS = bpc_pkg::DEF_MAX_PATTERN_BITS,
  parameter int POSITION_BITS    = bpc_pkg::DEF_POSITION_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bpc_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             bit_valid,
  output logic                             bit_stall,
  input  logic                             data_bit,
  input  logic                             end_of_stream,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [bpc_pkg::CNT_W-1:0]        agree_count,
  output logic                             peak,
  output logic [bpc_pkg::PHASE_W-1:0]      phase,
  output logic [bpc_pkg::OUT_POS_W-1:0]    aligned_position,
  output logic                             last_result
);

  localparam logic [bpc_pkg::LEN_W-1:0] MAX_LEN = bpc_pkg::LEN_W'(MAX_PATTERN_BITS);
  localparam logic [bpc_pkg::LEN_W-1:0] ONE     = bpc_pkg::LEN_W'(1);

  // Configuration registers.
  logic [bpc_pkg::PATTERN_W-1:0] pattern;
  logic [bpc_pkg::LEN_W-1:0]     pattern_length;

  // Sequencer state.
  logic                          flushing;
  logic [bpc_pkg::LEN_W-1:0]     flush_count;
  logic [bpc_pkg::LEN_W-1:0]     fill;
  logic [POSITION_BITS-1:0]      bit_position;

  // Cell row.
  logic [MAX_PATTERN_BITS-1:0]   ref_bit;
  logic [MAX_PATTERN_BITS-1:0]   ref_en;
  logic [MAX_PATTERN_BITS-1:0]   cell_bit;
  logic [MAX_PATTERN_BITS-1:0]   cell_present;
  logic [MAX_PATTERN_BITS-1:0]   match_bits;

  logic [bpc_pkg::LEN_W-1:0]     len_eff;
  logic [bpc_pkg::LEN_W-1:0]     fill_inc;
  logic                          ready;
  logic                          step;
  logic                          last_step;
  logic                          shift_bit;
  logic                          shift_present;
  bpc_pkg::meta_t                meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern        <= '0;
      pattern_length <= bpc_pkg::LEN_W'(8);
    end else if (cfg_write) begin
      case (cfg_index)
        bpc_pkg::REG_PATTERN: pattern        <= cfg_data;
        bpc_pkg::REG_LENGTH:  pattern_length <= cfg_data[bpc_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // A length of zero acts as one, and anything above the cell count is
  // clamped to the number of cells.
  always_comb begin
    if (pattern_length == '0) begin
      len_eff = ONE;
    end else if (pattern_length > MAX_LEN) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = pattern_length;
    end
  end

  // Cell d holds the stream bit d places back from the newest one; it lines
  // up with pattern element len-1-d, and cells at or beyond len stay out.
  always_comb begin
    logic [bpc_pkg::LEN_W-1:0] ridx;
    for (int d = 0; d < MAX_PATTERN_BITS; d++) begin
      ridx       = len_eff - ONE - bpc_pkg::LEN_W'(d);
      ref_en[d]  = bpc_pkg::LEN_W'(d) < len_eff;
      ref_bit[d] = ref_en[d] ? pattern[ridx[bpc_pkg::PIDX_W-1:0]] : 1'b0;
    end
  end

  // During a flush, empty slots enter the row so the pattern slides past the
  // end of the stream; new bits wait until the flush is over.
  assign bit_stall     = flushing || !ready;
  assign step          = ready && (flushing || bit_valid);
  assign shift_bit     = flushing ? 1'b0 : data_bit;
  assign shift_present = !flushing;
  assign fill_inc      = (fill == MAX_LEN) ? fill : fill + ONE;
  assign last_step     = flushing ? (flush_count == len_eff - ONE)
                                  : (end_of_stream && len_eff == ONE);

  always_comb begin
    meta.len  = len_eff;
    meta.last = last_step;
    meta.pos  = bpc_pkg::OUT_POS_W'(bit_position);
    if (flushing) begin
      meta.phase = bpc_pkg::PHASE_TRAIL;
    end else if (fill_inc >= len_eff) begin
      meta.phase = bpc_pkg::PHASE_FULL;
    end else begin
      meta.phase = bpc_pkg::PHASE_LEAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flushing     <= 1'b0;
      flush_count  <= '0;
      fill         <= '0;
      bit_position <= '0;
    end else if (step) begin
      if (last_step) begin
        // End of the stream: the next bit starts over at index zero.
        flushing     <= 1'b0;
        flush_count  <= '0;
        fill         <= '0;
        bit_position <= '0;
      end else if (flushing) begin
        flush_count  <= flush_count + ONE;
        bit_position <= bit_position + POSITION_BITS'(1);
      end else begin
        fill         <= fill_inc;
        bit_position <= bit_position + POSITION_BITS'(1);
        if (end_of_stream) begin
          flushing    <= 1'b1;
          flush_count <= ONE;
        end
      end
    end
  end

  for (genvar d = 0; d < MAX_PATTERN_BITS; d++) begin : g_cell
    logic cin_bit;
    logic cin_present;
    if (d == 0) begin : g_head
      assign cin_bit     = shift_bit;
      assign cin_present = shift_present;
    end else begin : g_body
      assign cin_bit     = cell_bit[d-1];
      assign cin_present = cell_present[d-1];
    end
    bpc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift      (step),
      .clear      (step && last_step),
      .bit_in     (cin_bit),
      .present_in (cin_present),
      .ref_bit    (ref_bit[d]),
      .ref_en     (ref_en[d]),
      .bit_q      (cell_bit[d]),
      .present_q  (cell_present[d]),
      .match      (match_bits[d])
    );
  end

  bpc_count #(
    .MAX_PATTERN_BITS (MAX_PATTERN_BITS)
  ) u_count (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .match_bits       (match_bits),
    .meta             (meta),
    .ready            (ready),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .agree_count      (agree_count),
    .peak             (peak),
    .phase            (phase),
    .aligned_position (aligned_position),
    .last_result      (last_result)
  );

  // A final bit with a multi-bit pattern must start the flush run.
  a_flush_start: assert property (@(posedge clk) disable iff (rst)
    (bit_valid && !bit_stall && end_of_stream && len_eff != ONE) |=> flushing)
    else $error("flush did not start after end of stream");

  // The count can never exceed the pattern length in use.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (agree_count <= len_eff))
    else $error("agreement count above pattern length");

  // Partial overlaps never reach a peak.
  a_no_partial_peak: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (phase == bpc_pkg::PHASE_LEAD || phase == bpc_pkg::PHASE_TRAIL))
      |-> !peak)
    else $error("peak flagged on a partial overlap");

endmodule

// ===== tb/bpc_checker.sv =====
// Scoreboard for the bit pattern correlator: tracks the register writes and bit beats,
// predicts every result beat and compares it with what the block delivers.
// Depends on bpc_pkg for widths, register indexes and phase codes.
`timescale 1ns / 1ps

module bpc_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          bit_valid,
  input  logic                          bit_stall,
  input  logic                          data_bit,
  input  logic                          end_of_stream,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  logic [bpc_pkg::CNT_W-1:0]     agree_count,
  input  logic                          peak,
  input  logic [bpc_pkg::PHASE_W-1:0]   phase,
  input  logic [bpc_pkg::OUT_POS_W-1:0] aligned_position,
  input  logic                          last_result,
  output int                            mismatches,
  output int                            outstanding
);
  import bpc_pkg::*;

  typedef struct packed {
    logic [CNT_W-1:0]     count;
    logic                 peak;
    logic [PHASE_W-1:0]   phase;
    logic [OUT_POS_W-1:0] pos;
    logic                 last;
  } corr_result_t;

  logic [PATTERN_W-1:0] pattern_q;
  logic [LEN_W-1:0]     length_q;
  logic [PATTERN_W-1:0] window_q;
  logic [PATTERN_W-1:0] present_q;
  logic [OUT_POS_W-1:0] next_pos_q;
  corr_result_t         expected_q[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // A length of zero behaves as one; anything past the maximum is clamped.
  function automatic int unsigned active_length(input logic [LEN_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > DEF_MAX_PATTERN_BITS) return DEF_MAX_PATTERN_BITS;
    return raw;
  endfunction

  // Agreements for the alignment that lies shift positions past the newest bit.
  function automatic int unsigned agreements(input int unsigned len, input int unsigned shift);
    int unsigned n;
    int unsigned d;
    n = 0;
    for (int unsigned k = 0; k < len; k++) begin
      d = len - 1 - k;
      if (d >= shift && present_q[d-shift] && window_q[d-shift] == pattern_q[k]) n++;
    end
    return n;
  endfunction

  function automatic corr_result_t make_result(input int unsigned cnt, input int unsigned len,
                                               input logic [PHASE_W-1:0] ph,
                                               input logic [OUT_POS_W-1:0] pos, input logic last);
    corr_result_t r;
    r.count = cnt[CNT_W-1:0];
    r.peak  = (cnt == len);
    r.phase = ph;
    r.pos   = pos;
    r.last  = last;
    return r;
  endfunction

  task automatic flag_result(input bit have_exp, input corr_result_t exp_r,
                             input corr_result_t got_r);
    mismatches++;
    if (mismatches <= 10) begin
      if (have_exp)
        $display("%0t bpc_checker: expected count=%0d peak=%0d phase=%0d pos=%0d last=%0d, got count=%0d peak=%0d phase=%0d pos=%0d last=%0d",
                 $realtime, exp_r.count, exp_r.peak, exp_r.phase, exp_r.pos, exp_r.last,
                 got_r.count, got_r.peak, got_r.phase, got_r.pos, got_r.last);
      else
        $display("%0t bpc_checker: unexpected result count=%0d peak=%0d phase=%0d pos=%0d last=%0d",
                 $realtime, got_r.count, got_r.peak, got_r.phase, got_r.pos, got_r.last);
    end
  endtask

  always @(posedge clk) begin : watch
    corr_result_t         exp_r;
    corr_result_t         got_r;
    int unsigned          len;
    int unsigned          cnt;
    logic [OUT_POS_W-1:0] pos;
    if (rst) begin
      pattern_q  = '0;
      length_q   = LEN_W'(8);
      window_q   = '0;
      present_q  = '0;
      next_pos_q = '0;
      expected_q.delete();
    end else begin
      if (bit_valid && !bit_stall) begin
        len       = active_length(length_q);
        pos       = next_pos_q;
        window_q  = {window_q[PATTERN_W-2:0], data_bit};
        present_q = {present_q[PATTERN_W-2:0], 1'b1};
        cnt       = agreements(len, 0);
        expected_q.push_back(make_result(cnt, len, present_q[len-1] ? PHASE_FULL : PHASE_LEAD,
                                         pos, end_of_stream && len == 1));
        if (end_of_stream) begin
          for (int unsigned s = 1; s < len; s++) begin
            cnt = agreements(len, s);
            expected_q.push_back(make_result(cnt, len, PHASE_TRAIL, pos + OUT_POS_W'(s),
                                             s == len - 1));
          end
          window_q   = '0;
          present_q  = '0;
          next_pos_q = '0;
        end else begin
          next_pos_q = pos + 1'b1;
        end
      end

      if (result_valid && !result_stall) begin
        got_r.count = agree_count;
        got_r.peak  = peak;
        got_r.phase = phase;
        got_r.pos   = aligned_position;
        got_r.last  = last_result;
        if (expected_q.size() == 0) begin
          flag_result(1'b0, got_r, got_r);
        end else begin
          exp_r = expected_q.pop_front();
          if (got_r.count !== exp_r.count || got_r.peak !== exp_r.peak ||
              got_r.phase !== exp_r.phase || got_r.pos !== exp_r.pos ||
              got_r.last !== exp_r.last)
            flag_result(1'b1, exp_r, got_r);
        end
      end

      // A register write takes effect for the next bit beat.
      if (cfg_write) begin
        if (cfg_index == REG_PATTERN) pattern_q = cfg_data;
        else if (cfg_index == REG_LENGTH) length_q = cfg_data[LEN_W-1:0];
      end
    end
    outstanding = expected_q.size();
  end

endmodule

// ===== tb/tb_bit_pattern_correlator.sv =====
// Top of the bit pattern correlator testbench: clock, reset, register writes,
// bit stream stimulus with random gaps and result back-pressure, and the verdict.
// Depends on bpc_pkg, bit_pattern_correlator and bpc_checker.
`timescale 1ns / 1ps

module tb_bit_pattern_correlator;
  import bpc_pkg::*;

  // Bit beats in the random part; the run stops adding phases after this many.
  localparam int RANDOM_ITEMS = 420;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 bit_valid;
  logic                 bit_stall;
  logic                 data_bit;
  logic                 end_of_stream;
  logic                 result_valid;
  logic                 result_stall;
  logic [CNT_W-1:0]     agree_count;
  logic                 peak;
  logic [PHASE_W-1:0]   phase;
  logic [OUT_POS_W-1:0] aligned_position;
  logic                 last_result;

  int mismatches;
  int outstanding;

  // Switches for the idle gaps on the bit side and the stalls on the result side.
  bit gaps_on;
  bit stalls_on;

  // Stimulus-side view of the current settings, used to plant pattern copies and to size the streams.
  logic [PATTERN_W-1:0] cur_pattern;
  int unsigned          cur_len;
  int unsigned          items_sent;

  bit_pattern_correlator i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .bit_valid        (bit_valid),
    .bit_stall        (bit_stall),
    .data_bit         (data_bit),
    .end_of_stream    (end_of_stream),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .agree_count      (agree_count),
    .peak             (peak),
    .phase            (phase),
    .aligned_position (aligned_position),
    .last_result      (last_result)
  );

  bpc_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .bit_valid        (bit_valid),
    .bit_stall        (bit_stall),
    .data_bit         (data_bit),
    .end_of_stream    (end_of_stream),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .agree_count      (agree_count),
    .peak             (peak),
    .phase            (phase),
    .aligned_position (aligned_position),
    .last_result      (last_result),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Safety net. The slowest legal run (every beat ending a 64-bit flush with
  // every result held by the longest stall) stays well below this.
  initial begin
    #50_000_000;
    $display("tb_bit_pattern_correlator: done, errors");
    $finish;
  end

  // Result-side back-pressure. Runs of ready cycles alternate with stalls of
  // random length, now and then a much longer one. When
  // stalls_on is clear the stall slots are simply left low.
  initial begin : result_backpressure
    int unsigned run;
    int unsigned hold;
    result_stall = 1'b0;
    forever begin
      run = $urandom_range(0, 12);
      repeat (run) @(negedge clk) result_stall <= 1'b0;
      hold = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(6, 40);
      repeat (hold) @(negedge clk) result_stall <= stalls_on;
    end
  end

  // Idle cycles ahead of a bit beat: mostly none, often a few, now and then many.
  function automatic int unsigned gap_cycles();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Register writes go through the plain write port, one cycle each.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Writes both registers. The length write sometimes carries junk above the
  // seven register bits, which the block must ignore.
  task automatic set_config(input logic [PATTERN_W-1:0] pat, input int unsigned raw_len);
    logic [CFG_W-1:0] len_word;
    len_word = {$urandom, $urandom};
    if ($urandom_range(0, 1) != 0) len_word = '0;
    len_word[LEN_W-1:0] = raw_len[LEN_W-1:0];
    write_reg(REG_PATTERN, pat);
    write_reg(REG_LENGTH, len_word);
    cur_pattern = pat;
    cur_len     = (raw_len == 0) ? 1 : (raw_len > DEF_MAX_PATTERN_BITS) ? DEF_MAX_PATTERN_BITS
                                                                        : raw_len;
  endtask

  // Stops the bit side and waits for every predicted result, including any
  // trailing flush, then lets the pipeline settle. The checker
  // updates its count at the rising edge, so it is read at the falling edge.
  task automatic drain();
    @(negedge clk);
    bit_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One bit beat. The payload is set at the falling edge and held until the
  // block takes it; while the beat is pending valid never drops.
  task automatic send_bit(input logic d, input logic eos);
    int unsigned gap;
    gap = gap_cycles();
    repeat (gap) begin
      @(negedge clk);
      bit_valid     <= 1'b0;
      data_bit      <= 1'($urandom_range(0, 1));
      end_of_stream <= 1'($urandom_range(0, 1));
    end
    @(negedge clk);
    bit_valid     <= 1'b1;
    data_bit      <= d;
    end_of_stream <= eos;
    @(posedge clk);
    while (bit_stall) @(posedge clk);
    items_sent++;
  endtask

  // A run of nbits random bits. With plant set, one copy of the pattern
  // (element 0 first) is laid into the run at a random offset so that full
  // matches actually occur. With close set the last bit ends the stream;
  // otherwise the stream carries on into the next run.
  task automatic send_stream(input int unsigned nbits, input bit close, input bit plant);
    int unsigned offset;
    logic        d;
    offset = (nbits > 0) ? $urandom_range(0, nbits - 1) : 0;
    for (int unsigned i = 0; i < nbits; i++) begin
      d = 1'($urandom_range(0, 1));
      if (plant && i >= offset && i < offset + cur_len) d = cur_pattern[i-offset];
      send_bit(d, close && (i == nbits - 1));
    end
  endtask

  initial begin : stimulus
    int unsigned          r;
    int unsigned          raw_len;
    int unsigned          nbits;
    logic [PATTERN_W-1:0] pat;

    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = REG_PATTERN;
    cfg_data      = '0;
    bit_valid     = 1'b0;
    data_bit      = 1'b0;
    end_of_stream = 1'b0;
    gaps_on       = 1'b0;
    stalls_on     = 1'b1;
    cur_pattern   = '0;
    cur_len       = 8;
    items_sent    = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. First a short stream under the reset settings (all-zero
    // pattern, eight bits), ending early so the flush covers a partial window.
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b0);
    send_bit(1'b1, 1'b1);

    // A length of zero must behave like a one-bit pattern.
    drain();
    set_config(64'h5, 0);
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b1);

    // Single-bit pattern: the end-of-stream beat gives exactly one result,
    // and that result is the last one.
    drain();
    set_config(64'h1, 1);
    send_bit(1'b1, 1'b1);

    // The pattern itself, element 0 first, gives a full-window peak.
    drain();
    set_config(64'hB, 4);
    send_bit(1'b1, 1'b0);
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b0);
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b1);

    // An oversized length clamps to the maximum; the flush then runs 63 results.
    drain();
    set_config('1, 100);
    send_bit(1'b1, 1'b0);
    send_bit(1'b1, 1'b1);

    // The length changes in the middle of a stream: the stored window is kept
    // and the new length applies from the next beat.
    drain();
    set_config(64'h2, 3);
    send_bit(1'b0, 1'b0);
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b0);
    drain();
    write_reg(REG_LENGTH, CFG_W'(5));
    cur_len = 5;
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b1);

    // Random part. Each phase drains the block, picks new settings (mostly
    // short patterns, with the extremes mixed in), decides whether this phase
    // idles and stalls, and sends a few streams. Most streams are closed and most carry
    // a planted copy of the pattern; the rest are plain noise or run on.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      drain();
      r = $urandom_range(0, 99);
      if (r < 5) raw_len = 0;
      else if (r < 10) raw_len = $urandom_range(65, 127);
      else if (r < 16) raw_len = 64;
      else if (r < 24) raw_len = $urandom_range(13, 63);
      else if (r < 32) raw_len = 1;
      else raw_len = $urandom_range(2, 12);
      r = $urandom_range(0, 9);
      if (r == 0) pat = '1;
      else if (r == 1) pat = '0;
      else pat = {$urandom, $urandom};
      set_config(pat, raw_len);
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 4)) begin
        if (cur_len <= 12) nbits = $urandom_range(1, 3 * cur_len + 4);
        else nbits = $urandom_range(1, cur_len + 16);
        send_stream(nbits, $urandom_range(0, 9) != 0, $urandom_range(0, 2) != 0);
      end
    end

    // Let every expected result come home, then keep watching so that anything
    // stray still shows.
    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("tb_bit_pattern_correlator: done, clean");
    else
      $display("tb_bit_pattern_correlator: done, errors");
    $finish;
  end

endmodule
